@@ rtl/mcc_pkg.sv @@
// Shared types and constants of the matmul command collector.
// Used by every module of the block but mcc_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;

  localparam int TOTAL_WARPS    = 16;
  localparam int TAG_SLOTS      = 4;
  localparam int WORDS_PER_WARP = 9;
  localparam int COMMIT_WORD    = 8;
  localparam int DESC_WORDS     = 8;

  localparam int IDX_W     = 14;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 8;
  localparam int WARP_W    = (TOTAL_WARPS > 1) ? $clog2(TOTAL_WARPS) : 1;
  localparam int TAG_W     = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  localparam int LANE_W    = $clog2(DESC_WORDS);
  localparam int REM_W     = $clog2(WORDS_PER_WARP);
  localparam int PROD_W    = 2 * IDX_W + 4;

  // Reciprocal of nine: exact quotient for every 14-bit index.
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + WORDS_PER_WARP - 1) / WORDS_PER_WARP;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_LAUNCH = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_COMMIT,
    OP_REJECT
  } op_t;

  typedef enum logic {
    BK_EXEC,
    BK_LAUNCH
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [WARP_W-1:0] warp;
    logic [LANE_W-1:0] lane;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

@@ rtl/mcc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module mcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcc_front.sv @@
// Front end: decodes a bus access into a classified operation.
// Depends on mcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcc_front (
  input  wire logic                        in_action,
  input  wire logic [mcc_pkg::IDX_W-1:0]   in_word_index,
  input  wire logic [mcc_pkg::DATA_W-1:0]  in_write_data,
  output mcc_pkg::item_t                   item
);

  logic [mcc_pkg::PROD_W-1:0] prod;
  logic [mcc_pkg::IDX_W-1:0]  quot;
  logic [mcc_pkg::IDX_W-1:0]  quot9;
  logic [mcc_pkg::IDX_W-1:0]  rem_full;
  logic [mcc_pkg::REM_W-1:0]  rem;
  logic                       warp_ok;
  logic                       read_ok;
  logic                       tag_ok;

  always_comb begin
    prod     = mcc_pkg::PROD_W'(in_word_index) * mcc_pkg::PROD_W'(mcc_pkg::RECIP_MULT);
    quot     = mcc_pkg::IDX_W'(prod >> mcc_pkg::RECIP_SHIFT);
    quot9    = (quot << 3) + quot;
    rem_full = in_word_index - quot9;
    rem      = rem_full[mcc_pkg::REM_W-1:0];
    warp_ok  = quot < mcc_pkg::IDX_W'(mcc_pkg::TOTAL_WARPS);
    read_ok  = in_word_index < mcc_pkg::IDX_W'(mcc_pkg::TOTAL_WARPS);
    tag_ok   = in_write_data < mcc_pkg::DATA_W'(mcc_pkg::TAG_SLOTS);

    item.data = in_write_data;
    item.lane = rem[mcc_pkg::LANE_W-1:0];
    if (in_action) begin
      item.warp = quot[mcc_pkg::WARP_W-1:0];
      if (!warp_ok) begin
        item.op = mcc_pkg::OP_REJECT;
      end else if (rem == mcc_pkg::REM_W'(mcc_pkg::COMMIT_WORD)) begin
        item.op = tag_ok ? mcc_pkg::OP_COMMIT : mcc_pkg::OP_REJECT;
      end else begin
        item.op = mcc_pkg::OP_WRITE;
      end
    end else begin
      item.warp = in_word_index[mcc_pkg::WARP_W-1:0];
      item.op   = read_ok ? mcc_pkg::OP_READ : mcc_pkg::OP_REJECT;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcc_queue.sv @@
// Two-entry queue of classified operations between front and back end.
// Depends on mcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mcc_pkg::item_t push_item,
  input  wire logic           pop,
  output mcc_pkg::item_t      head_item,
  output mcc_pkg::q_stat_t    stat
);

  mcc_pkg::item_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    stat.valid = count_r != 2'd0;
    stat.full  = count_r == 2'd2;
    head_item  = entry_r[rd_ptr_r];
    do_push    = push && !stat.full;
    do_pop     = pop && stat.valid;
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcc_back.sv @@
// Back end: executes queued operations, holds command words, tag bits and
// pending counts, and drives the result register. Depends on mcc_pkg, mcc_ram.
`timescale 1ns / 1ps
`default_nettype none
module mcc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mcc_pkg::q_stat_t            q_stat,
  input  wire mcc_pkg::item_t              q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [7:0]                       out_read_data,
  output logic [31:0]                      out_src_a_address,
  output logic [31:0]                      out_src_b_address,
  output logic [31:0]                      out_dest_address,
  output logic [31:0]                      out_element_type,
  output logic [31:0]                      out_rows_of_a,
  output logic [31:0]                      out_cols_of_a,
  output logic [31:0]                      out_cols_of_b,
  output logic [14:0]                      out_accumulator_offset,
  output logic [1:0]                       out_launch_tag,
  output logic [1:0]                       out_mode_bits
);

  localparam int NW = mcc_pkg::TOTAL_WARPS;
  localparam int NL = mcc_pkg::DESC_WORDS;

  mcc_pkg::bk_state_t state_r, state_nxt;

  logic [mcc_pkg::TAG_SLOTS-1:0][NW-1:0]       tag_bits_r, tag_bits_nxt;
  logic [NW-1:0][mcc_pkg::CNT_W-1:0]           pend_r, pend_nxt;
  logic [NL-1:0][NW-1:0]                       word_valid_r, word_valid_nxt;
  logic [NL-1:0]                               rd_valid_r, rd_valid_nxt;
  logic [mcc_pkg::TAG_W-1:0]                   tag_r, tag_nxt;

  logic                                        out_valid_r, out_valid_nxt;
  logic [1:0]                                  status_r, status_nxt;
  logic [7:0]                                  rdata_r, rdata_nxt;
  logic [NL-2:0][31:0]                         desc_r, desc_nxt;
  logic [14:0]                                 acc_off_r, acc_off_nxt;
  logic [1:0]                                  ltag_r, ltag_nxt;
  logic [1:0]                                  mode_r, mode_nxt;

  logic [NL-1:0]                               lane_wr;
  logic                                        rd_en;
  logic [NL-1:0][31:0]                         lane_rdata;
  logic [NL-1:0][31:0]                         lane_word;
  logic                                        load_ok;
  logic [mcc_pkg::TAG_W-1:0]                   item_tag;
  logic [NW-1:0]                               warp_bit;
  logic [NW-1:0]                               bits_new;

  genvar gl;
  generate
    for (gl = 0; gl < NL; gl++) begin : g_lane
      mcc_ram #(
        .WIDTH(32),
        .DEPTH(NW)
      ) u_ram (
        .clk    (clk),
        .wr_en  (lane_wr[gl]),
        .wr_addr(q_item.warp),
        .wr_data(q_item.data),
        .rd_en  (rd_en),
        .rd_addr(q_item.warp),
        .rd_data(lane_rdata[gl])
      );
      assign lane_word[gl] = rd_valid_r[gl] ? lane_rdata[gl] : 32'd0;
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    tag_bits_nxt   = tag_bits_r;
    pend_nxt       = pend_r;
    word_valid_nxt = word_valid_r;
    rd_valid_nxt   = rd_valid_r;
    tag_nxt        = tag_r;
    status_nxt     = status_r;
    rdata_nxt      = rdata_r;
    desc_nxt       = desc_r;
    acc_off_nxt    = acc_off_r;
    ltag_nxt       = ltag_r;
    mode_nxt       = mode_r;
    lane_wr        = '0;
    rd_en          = 1'b0;
    q_pop          = 1'b0;

    load_ok       = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    item_tag      = q_item.data[mcc_pkg::TAG_W-1:0];
    warp_bit      = NW'(1) << q_item.warp;
    bits_new      = tag_bits_r[item_tag] | warp_bit;

    unique case (state_r)
      mcc_pkg::BK_EXEC: begin
        if (q_stat.valid && load_ok) begin
          q_pop       = 1'b1;
          status_nxt  = mcc_pkg::STAT_OK;
          rdata_nxt   = '0;
          desc_nxt    = '0;
          acc_off_nxt = '0;
          ltag_nxt    = '0;
          mode_nxt    = '0;
          out_valid_nxt = 1'b1;
          unique case (q_item.op)
            mcc_pkg::OP_READ: begin
              rdata_nxt = pend_r[q_item.warp];
            end
            mcc_pkg::OP_REJECT: begin
              status_nxt = mcc_pkg::STAT_REJECT;
            end
            mcc_pkg::OP_WRITE: begin
              lane_wr[q_item.lane]                    = 1'b1;
              word_valid_nxt[q_item.lane][q_item.warp] = 1'b1;
            end
            mcc_pkg::OP_COMMIT: begin
              if (pend_r[q_item.warp] != mcc_pkg::CNT_MAX) begin
                pend_nxt[q_item.warp] = pend_r[q_item.warp] + 1'b1;
              end
              if (&bits_new) begin
                tag_bits_nxt[item_tag] = '0;
                for (int k = 0; k < NW; k++) begin
                  if (pend_nxt[k] != '0) begin
                    pend_nxt[k] = pend_nxt[k] - 1'b1;
                  end
                end
                for (int l = 0; l < NL; l++) begin
                  rd_valid_nxt[l] = word_valid_r[l][q_item.warp];
                end
                rd_en         = 1'b1;
                tag_nxt       = item_tag;
                out_valid_nxt = 1'b0;
                state_nxt     = mcc_pkg::BK_LAUNCH;
              end else begin
                tag_bits_nxt[item_tag] = bits_new;
              end
            end
            default: begin
              status_nxt = mcc_pkg::STAT_REJECT;
            end
          endcase
        end
      end
      mcc_pkg::BK_LAUNCH: begin
        out_valid_nxt = 1'b1;
        status_nxt    = mcc_pkg::STAT_LAUNCH;
        rdata_nxt     = '0;
        for (int l = 0; l < NL - 1; l++) begin
          desc_nxt[l] = lane_word[l];
        end
        acc_off_nxt = lane_word[NL-1][14:0];
        ltag_nxt    = 2'(tag_r);
        mode_nxt    = {lane_word[NL-1][31], lane_word[NL-1][30]};
        state_nxt   = mcc_pkg::BK_EXEC;
      end
      default: begin
        state_nxt = mcc_pkg::BK_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mcc_pkg::BK_EXEC;
      tag_bits_r   <= '0;
      pend_r       <= '0;
      word_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tag_bits_r   <= tag_bits_nxt;
      pend_r       <= pend_nxt;
      word_valid_r <= word_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= rd_valid_nxt;
    tag_r      <= tag_nxt;
    status_r   <= status_nxt;
    rdata_r    <= rdata_nxt;
    desc_r     <= desc_nxt;
    acc_off_r  <= acc_off_nxt;
    ltag_r     <= ltag_nxt;
    mode_r     <= mode_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_read_data          = rdata_r;
  assign out_src_a_address      = desc_r[0];
  assign out_src_b_address      = desc_r[1];
  assign out_dest_address       = desc_r[2];
  assign out_element_type       = desc_r[3];
  assign out_rows_of_a          = desc_r[4];
  assign out_cols_of_a          = desc_r[5];
  assign out_cols_of_b          = desc_r[6];
  assign out_accumulator_offset = acc_off_r;
  assign out_launch_tag         = ltag_r;
  assign out_mode_bits          = mode_r;

endmodule
`default_nettype wire

@@ rtl/matmul_command_collector.sv @@
// Matmul command collector: one result word per bus access word.
// An accepted word passes the queue and the result register; a launching
// access also passes the launch state, which reads the command-word RAMs.
// Throughput is one word per cycle unless the output stalls or a launch holds
// the execute unit. Synchronous active-low reset clears counts, tag bits, the
// word valid bits and the handshakes; RAM contents read as zero until written.
`timescale 1ns / 1ps
`default_nettype none
module matmul_command_collector (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_action,
  input  wire logic [13:0]  in_word_index,
  input  wire logic [31:0]  in_write_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        out_status,
  output logic [7:0]        out_read_data,
  output logic [31:0]       out_src_a_address,
  output logic [31:0]       out_src_b_address,
  output logic [31:0]       out_dest_address,
  output logic [31:0]       out_element_type,
  output logic [31:0]       out_rows_of_a,
  output logic [31:0]       out_cols_of_a,
  output logic [31:0]       out_cols_of_b,
  output logic [14:0]       out_accumulator_offset,
  output logic [1:0]        out_launch_tag,
  output logic [1:0]        out_mode_bits
);

  mcc_pkg::item_t   front_item;
  mcc_pkg::item_t   head_item;
  mcc_pkg::q_stat_t q_stat;
  logic             q_pop;

  mcc_front u_front (
    .in_action    (in_action),
    .in_word_index(in_word_index),
    .in_write_data(in_write_data),
    .item         (front_item)
  );

  mcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_item(front_item),
    .pop      (q_pop),
    .head_item(head_item),
    .stat     (q_stat)
  );

  assign in_stall = q_stat.full;

  mcc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_stat                (q_stat),
    .q_item                (head_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_read_data         (out_read_data),
    .out_src_a_address     (out_src_a_address),
    .out_src_b_address     (out_src_b_address),
    .out_dest_address      (out_dest_address),
    .out_element_type      (out_element_type),
    .out_rows_of_a         (out_rows_of_a),
    .out_cols_of_a         (out_cols_of_a),
    .out_cols_of_b         (out_cols_of_b),
    .out_accumulator_offset(out_accumulator_offset),
    .out_launch_tag        (out_launch_tag),
    .out_mode_bits         (out_mode_bits)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> q_stat.valid)
    else $error("Accepted word did not reach the queue.");

  a_plain_no_desc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != mcc_pkg::STAT_LAUNCH) |->
      out_launch_tag == 2'd0 && out_mode_bits == 2'd0 && out_accumulator_offset == 15'd0)
    else $error("Descriptor fields set on a result without launch.");

  a_launch_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mcc_pkg::STAT_LAUNCH || out_status == mcc_pkg::STAT_REJECT) |->
      out_read_data == 8'd0)
    else $error("Read data set on a launch or rejected access.");

endmodule
`default_nettype wire

@@ sim/mcc_result_checker.sv @@
// Result checker for the matmul command collector: predicts each bus access and
// compares every result word field by field. Depends on mcc_pkg.
`timescale 1ns / 1ps
module mcc_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [13:0] in_word_index,
  input  logic [31:0] in_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_read_data,
  input  logic [31:0] out_src_a_address,
  input  logic [31:0] out_src_b_address,
  input  logic [31:0] out_dest_address,
  input  logic [31:0] out_element_type,
  input  logic [31:0] out_rows_of_a,
  input  logic [31:0] out_cols_of_a,
  input  logic [31:0] out_cols_of_b,
  input  logic [14:0] out_accumulator_offset,
  input  logic [1:0]  out_launch_tag,
  input  logic [1:0]  out_mode_bits,
  output int          error_count,
  output int          results_owed
);
  import mcc_pkg::*;

  typedef struct {
    status_t     status;
    logic [7:0]  read_data;
    logic [31:0] src_a;
    logic [31:0] src_b;
    logic [31:0] dest;
    logic [31:0] elem_type;
    logic [31:0] rows_a;
    logic [31:0] cols_a;
    logic [31:0] cols_b;
    logic [14:0] acc_offset;
    logic [1:0]  tag;
    logic [1:0]  mode;
  } access_result_t;

  logic [DATA_W-1:0]      cmd_words [TOTAL_WARPS*WORDS_PER_WARP];
  logic [TOTAL_WARPS-1:0] commit_mask [TAG_SLOTS];
  logic [CNT_W-1:0]       warp_counts [TOTAL_WARPS];
  access_result_t         owed_results [$];

  function automatic access_result_t predict_access(input logic is_write,
                                                    input logic [13:0] idx,
                                                    input logic [31:0] data);
    access_result_t r;
    int warp;
    int word;
    int base;
    int tag;
    logic [31:0] w7;
    r.status     = STAT_OK;
    r.read_data  = '0;
    r.src_a      = '0;
    r.src_b      = '0;
    r.dest       = '0;
    r.elem_type  = '0;
    r.rows_a     = '0;
    r.cols_a     = '0;
    r.cols_b     = '0;
    r.acc_offset = '0;
    r.tag        = '0;
    r.mode       = '0;
    if (!is_write) begin
      if (int'(idx) >= TOTAL_WARPS) r.status = STAT_REJECT;
      else r.read_data = warp_counts[idx];
      return r;
    end
    warp = int'(idx) / WORDS_PER_WARP;
    word = int'(idx) % WORDS_PER_WARP;
    if (warp >= TOTAL_WARPS) begin
      r.status = STAT_REJECT;
      return r;
    end
    base = warp * WORDS_PER_WARP;
    if (word != COMMIT_WORD) begin
      cmd_words[base + word] = data;
      return r;
    end
    if (data >= TAG_SLOTS) begin
      r.status = STAT_REJECT;
      return r;
    end
    tag = int'(data);
    cmd_words[base + word] = data;
    commit_mask[tag][warp] = 1'b1;
    if (warp_counts[warp] != CNT_MAX) warp_counts[warp]++;
    if (&commit_mask[tag]) begin
      commit_mask[tag] = '0;
      w7           = cmd_words[base + 7];
      r.status     = STAT_LAUNCH;
      r.src_a      = cmd_words[base + 0];
      r.src_b      = cmd_words[base + 1];
      r.dest       = cmd_words[base + 2];
      r.elem_type  = cmd_words[base + 3];
      r.rows_a     = cmd_words[base + 4];
      r.cols_a     = cmd_words[base + 5];
      r.cols_b     = cmd_words[base + 6];
      r.acc_offset = w7[14:0];
      r.tag        = 2'(tag);
      r.mode       = {w7[31], w7[30]};
      foreach (warp_counts[k]) begin
        if (warp_counts[k] != '0) warp_counts[k]--;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      error_count++;
    end
  endtask

  task automatic compare_result(input access_result_t want);
    check_field("status", want.status, out_status);
    check_field("read_data", want.read_data, out_read_data);
    check_field("src_a_address", want.src_a, out_src_a_address);
    check_field("src_b_address", want.src_b, out_src_b_address);
    check_field("dest_address", want.dest, out_dest_address);
    check_field("element_type", want.elem_type, out_element_type);
    check_field("rows_of_a", want.rows_a, out_rows_of_a);
    check_field("cols_of_a", want.cols_a, out_cols_of_a);
    check_field("cols_of_b", want.cols_b, out_cols_of_b);
    check_field("accumulator_offset", want.acc_offset, out_accumulator_offset);
    check_field("launch_tag", want.tag, out_launch_tag);
    check_field("mode_bits", want.mode, out_mode_bits);
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      foreach (cmd_words[i]) cmd_words[i] = '0;
      foreach (commit_mask[i]) commit_mask[i] = '0;
      foreach (warp_counts[i]) warp_counts[i] = '0;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got status %0d",
                   $time, out_status);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          compare_result(want);
        end
      end
      if (in_valid && !in_stall)
        owed_results.push_back(predict_access(in_action, in_word_index, in_write_data));
    end
    results_owed = owed_results.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the matmul command collector testbench: clock, reset, bus access stimulus
// and verdict. Depends on mcc_pkg, mcc_result_checker and the collector RTL.
`timescale 1ns / 1ps
module testbench;
  import mcc_pkg::*;

  localparam logic ACT_READ     = 1'b0;
  localparam logic ACT_WRITE    = 1'b1;
  localparam int   IDLE_PCT     = 29;
  localparam int   RANDOM_ITEMS = 900;
  localparam int   CALM_FROM    = 500;
  localparam int   CALM_TO      = 700;
  localparam int   SAT_COMMITS  = 260;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   LIMIT_CYCLES = 100000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_action = 1'b0;
  logic [13:0] in_word_index = '0;
  logic [31:0] in_write_data = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_read_data;
  logic [31:0] out_src_a_address;
  logic [31:0] out_src_b_address;
  logic [31:0] out_dest_address;
  logic [31:0] out_element_type;
  logic [31:0] out_rows_of_a;
  logic [31:0] out_cols_of_a;
  logic [31:0] out_cols_of_b;
  logic [14:0] out_accumulator_offset;
  logic [1:0]  out_launch_tag;
  logic [1:0]  out_mode_bits;
  int          error_count;
  int          results_owed;
  int          issued = 0;
  int          cycle_count = 0;
  logic        calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  matmul_command_collector DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_word_index, .in_write_data,
    .out_valid, .out_stall, .out_status, .out_read_data, .out_src_a_address,
    .out_src_b_address, .out_dest_address, .out_element_type, .out_rows_of_a,
    .out_cols_of_a, .out_cols_of_b, .out_accumulator_offset, .out_launch_tag,
    .out_mode_bits
  );

  mcc_result_checker result_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_word_index, .in_write_data,
    .out_valid, .out_stall, .out_status, .out_read_data, .out_src_a_address,
    .out_src_b_address, .out_dest_address, .out_element_type, .out_rows_of_a,
    .out_cols_of_a, .out_cols_of_b, .out_accumulator_offset, .out_launch_tag,
    .out_mode_bits, .error_count, .results_owed
  );

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [13:0] word_addr(input int warp, input int word);
    return 14'(warp * WORDS_PER_WARP + word);
  endfunction

  task automatic send_word(input logic act, input logic [13:0] idx,
                           input logic [31:0] data);
    calm = (issued >= CALM_FROM) && (issued < CALM_TO);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_word_index <= idx;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    issued++;
  endtask

  task automatic commit(input int warp, input int tag);
    send_word(ACT_WRITE, word_addr(warp, COMMIT_WORD), 32'(tag));
  endtask

  task automatic write_random_word();
    send_word(ACT_WRITE, word_addr($urandom_range(TOTAL_WARPS - 1), $urandom_range(7)),
              $urandom);
  endtask

  // One pass of every warp committing the same tag, in shuffled order, with
  // command-word writes and count reads mixed in; some passes break off early.
  task automatic launch_round();
    int order [TOTAL_WARPS];
    int tag;
    int j;
    int tmp;
    int stop_at;
    tag = $urandom_range(TAG_SLOTS - 1);
    foreach (order[i]) order[i] = i;
    for (int i = TOTAL_WARPS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    stop_at = ($urandom_range(99) < 15) ? $urandom_range(TOTAL_WARPS - 1) : TOTAL_WARPS;
    for (int k = 0; k < stop_at; k++) begin
      repeat ($urandom_range(2)) write_random_word();
      if ($urandom_range(9) == 0)
        send_word(ACT_READ, 14'($urandom_range(TOTAL_WARPS - 1)), $urandom);
      commit(order[k], tag);
    end
  endtask

  task automatic noise_access();
    case ($urandom_range(3))
      0: send_word(1'($urandom_range(1)), 14'($urandom_range(16383)), $urandom);
      1: send_word(ACT_WRITE, word_addr($urandom_range(TOTAL_WARPS - 1), COMMIT_WORD),
                   $urandom_range(1) ? $urandom : 32'(TAG_SLOTS + $urandom_range(3)));
      2: commit($urandom_range(TOTAL_WARPS - 1), $urandom_range(TAG_SLOTS - 1));
      default: send_word(ACT_READ, 14'($urandom_range(TOTAL_WARPS + 3)), $urandom);
    endcase
  endtask

  initial begin
    int rand_start;
    int sat_warp;
    int sat_tag;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads at both ends of the warp range and just past it.
    send_word(ACT_READ, 14'd0, 32'h0);
    send_word(ACT_READ, 14'(TOTAL_WARPS - 1), 32'hFFFF_FFFF);
    send_word(ACT_READ, 14'(TOTAL_WARPS), 32'h0);
    send_word(ACT_READ, 14'h3FFF, 32'h0);
    // Descriptor words of the last warp, then writes to missing warps.
    send_word(ACT_WRITE, word_addr(TOTAL_WARPS - 1, 0), 32'hFFFF_FFFF);
    send_word(ACT_WRITE, word_addr(TOTAL_WARPS - 1, 7), 32'hC000_7FFF);
    send_word(ACT_WRITE, word_addr(TOTAL_WARPS, 0), 32'h1234_5678);
    send_word(ACT_WRITE, 14'h3FFF, 32'hFFFF_FFFF);
    // Bad tags, a repeated commit, then a full launch from the last warp.
    send_word(ACT_WRITE, word_addr(3, COMMIT_WORD), 32'(TAG_SLOTS));
    send_word(ACT_WRITE, word_addr(3, COMMIT_WORD), 32'hFFFF_FFFF);
    commit(0, TAG_SLOTS - 1);
    for (int w = 0; w < TOTAL_WARPS; w++) commit(w, TAG_SLOTS - 1);
    send_word(ACT_READ, 14'd0, 32'h0);
    send_word(ACT_READ, 14'd5, 32'h0);

    rand_start = issued;
    // Drive one warp's pending count into saturation without a launch.
    sat_warp = $urandom_range(TOTAL_WARPS - 1);
    sat_tag  = $urandom_range(TAG_SLOTS - 1);
    for (int n = 0; n < SAT_COMMITS; n++) begin
      commit(sat_warp, sat_tag);
      if (n % 50 == 0 || n > SAT_COMMITS - 4) send_word(ACT_READ, 14'(sat_warp), $urandom);
    end
    while (issued - rand_start < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 60) launch_round();
      else if ($urandom_range(99) < 70) noise_access();
      else write_random_word();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
